### rtl/xxtea_pkg.sv
package xxtea_pkg;

    localparam int WORD_W            = 32;
    localparam int KEY_WORDS         = 4;
    localparam int ROUNDS_W          = 6;
    localparam int CFG_ADDR_W        = 4;
    localparam int DEFAULT_MAX_WORDS = 64;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

    // controller to datapath commands
    typedef struct packed {
        logic                mem_we;
        logic                cap_first;
        logic                init_chain;
        logic                sum_init;
        logic                mix_en;
        logic                sum_step;
        logic                decrypt;
        logic [ROUNDS_W-1:0] rounds;
    } cmd_t;

endpackage

### rtl/xxtea_if.sv
interface xxtea_in_if;
    import xxtea_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data_in;
    logic              last_in;
    logic              func;

    modport source (output valid, output data_in, output last_in, output func, input ready);
    modport sink   (input valid, input data_in, input last_in, input func, output ready);
endinterface

interface xxtea_out_if;
    import xxtea_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data_out;
    logic              last_out;

    modport source (output valid, output data_out, output last_out, input ready);
    modport sink   (input valid, input data_out, input last_out, output ready);
endinterface

### rtl/xxtea_dp.sv
module xxtea_dp #(
    parameter int MAX_WORDS = xxtea_pkg::DEFAULT_MAX_WORDS,
    parameter int AW        = $clog2(MAX_WORDS)
) (
    input  logic                        clk,
    input  xxtea_pkg::cmd_t             cmd,
    input  logic [AW-1:0]               waddr,
    input  logic [AW-1:0]               raddr,
    input  logic [xxtea_pkg::WORD_W-1:0] data_in,
    input  xxtea_pkg::key_t             key,
    output logic [xxtea_pkg::WORD_W-1:0] data_out
);
    import xxtea_pkg::*;

    logic [WORD_W-1:0] msg_mem [MAX_WORDS];
    logic [WORD_W-1:0] rd_reg;
    logic [WORD_W-1:0] first_reg;
    logic [WORD_W-1:0] chain_reg;
    logic [WORD_W-1:0] cur_reg;
    logic [WORD_W-1:0] sum_reg;

    logic              we;
    logic [WORD_W-1:0] wdata;
    logic [WORD_W-1:0] y_word;
    logic [WORD_W-1:0] z_word;
    logic [WORD_W-1:0] term;
    logic [WORD_W-1:0] new_word;

    function automatic logic [WORD_W-1:0] mix_term(
        input logic [WORD_W-1:0] y,
        input logic [WORD_W-1:0] z,
        input logic [WORD_W-1:0] sum,
        input key_t              k,
        input logic [1:0]        p_lo
    );
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [1:0]        idx;
        a   = (z >> 5) ^ (y << 2);
        b   = (y >> 3) ^ (z << 4);
        idx = p_lo ^ sum[3:2];
        c   = (sum ^ y) + (k[idx] ^ z);
        return (a + b) ^ c;
    endfunction

    // encrypt: memory operand is y, chain is z; decrypt swaps them
    always_comb
    begin
        y_word   = cmd.decrypt ? chain_reg : rd_reg;
        z_word   = cmd.decrypt ? rd_reg : chain_reg;
        term     = mix_term(y_word, z_word, sum_reg, key, 2'(waddr));
        new_word = cmd.decrypt ? (cur_reg - term) : (cur_reg + term);
        we       = cmd.mem_we | cmd.mix_en;
        wdata    = cmd.mix_en ? new_word : data_in;
    end

    // write-first read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            msg_mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rd_reg <= wdata;
        end
        else
        begin
            rd_reg <= msg_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_first)
        begin
            first_reg <= data_in;
        end
        if (cmd.init_chain)
        begin
            chain_reg <= cmd.decrypt ? first_reg : data_in;
            cur_reg   <= cmd.decrypt ? data_in : first_reg;
        end
        else if (cmd.mix_en)
        begin
            chain_reg <= new_word;
            cur_reg   <= rd_reg;
        end
        if (cmd.sum_init)
        begin
            sum_reg <= cmd.decrypt ? WORD_W'({26'd0, cmd.rounds} * TEA_DELTA) : TEA_DELTA;
        end
        else if (cmd.sum_step)
        begin
            sum_reg <= cmd.decrypt ? (sum_reg - TEA_DELTA) : (sum_reg + TEA_DELTA);
        end
    end

    assign data_out = rd_reg;

endmodule

### rtl/xxtea_ctrl.sv
module xxtea_ctrl #(
    parameter int MAX_WORDS = xxtea_pkg::DEFAULT_MAX_WORDS,
    parameter int AW        = $clog2(MAX_WORDS),
    parameter int CW        = $clog2(MAX_WORDS + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_last,
    input  logic            in_func,
    output logic            in_ready,
    input  logic            out_ready,
    output logic            out_valid,
    output logic            out_last,
    output xxtea_pkg::cmd_t cmd,
    output logic [AW-1:0]   waddr,
    output logic [AW-1:0]   raddr
);
    import xxtea_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PRIME,
        ST_MIX,
        ST_FETCH,
        ST_SHOW
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       count_reg;
    logic [AW-1:0]       p_reg;
    logic [AW-1:0]       k_reg;
    logic [ROUNDS_W-1:0] rounds_reg;
    logic                mode_reg;

    logic                accept;
    logic                msg_end;
    logic                out_fire;
    logic                round_end;
    logic [CW-1:0]       cnt_m1;
    logic [CW-1:0]       n_now;
    logic [AW-1:0]       last_idx;
    logic [AW-1:0]       next_p;

    function automatic logic [ROUNDS_W-1:0] rounds_for(input logic [6:0] n);
        logic [ROUNDS_W-1:0] r;
        case (n) inside
            7'd2:           r = 6'd32;
            7'd3:           r = 6'd23;
            7'd4:           r = 6'd19;
            7'd5:           r = 6'd16;
            7'd6:           r = 6'd14;
            7'd7:           r = 6'd13;
            7'd8:           r = 6'd12;
            [7'd9:7'd10]:   r = 6'd11;
            [7'd11:7'd13]:  r = 6'd10;
            [7'd14:7'd17]:  r = 6'd9;
            [7'd18:7'd26]:  r = 6'd8;
            [7'd27:7'd52]:  r = 6'd7;
            default:        r = 6'd6;
        endcase
        return r;
    endfunction

    function automatic logic [AW-1:0] succ(input logic [AW-1:0] x, input logic [AW-1:0] last);
        return (x == last) ? '0 : x + AW'(1);
    endfunction

    function automatic logic [AW-1:0] pred(input logic [AW-1:0] x, input logic [AW-1:0] last);
        return (x == '0) ? last : x - AW'(1);
    endfunction

    always_comb
    begin
        cnt_m1    = count_reg - CW'(1);
        n_now     = count_reg + CW'(1);
        last_idx  = cnt_m1[AW-1:0];
        accept    = in_valid && (state_reg == ST_LOAD);
        msg_end   = in_last || (count_reg == CW'(MAX_WORDS - 1));
        out_fire  = out_ready && (state_reg == ST_SHOW);
        next_p    = mode_reg ? pred(p_reg, last_idx) : succ(p_reg, last_idx);
        round_end = mode_reg ? (p_reg == '0) : (p_reg == last_idx);

        in_ready  = (state_reg == ST_LOAD);
        out_valid = (state_reg == ST_SHOW);
        out_last  = (k_reg == last_idx);

        cmd            = '0;
        cmd.decrypt    = mode_reg;
        cmd.rounds     = rounds_reg;
        waddr          = p_reg;
        raddr          = '0;

        case (state_reg)
            ST_LOAD:
            begin
                waddr          = count_reg[AW-1:0];
                cmd.mem_we     = accept;
                cmd.cap_first  = accept && (count_reg == '0);
                cmd.init_chain = accept && msg_end && (count_reg != '0);
            end
            ST_PRIME:
            begin
                cmd.sum_init = 1'b1;
                raddr        = mode_reg ? pred(p_reg, last_idx) : succ(p_reg, last_idx);
            end
            ST_MIX:
            begin
                cmd.mix_en   = 1'b1;
                cmd.sum_step = round_end;
                raddr        = mode_reg ? pred(next_p, last_idx) : succ(next_p, last_idx);
            end
            ST_FETCH:
            begin
                raddr = '0;
            end
            ST_SHOW:
            begin
                raddr = (out_fire && (k_reg != last_idx)) ? k_reg + AW'(1) : k_reg;
            end
            default:
            begin
                raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            count_reg  <= '0;
            p_reg      <= '0;
            k_reg      <= '0;
            rounds_reg <= '0;
            mode_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        count_reg <= n_now;
                        if (count_reg == '0)
                        begin
                            mode_reg <= in_func;
                        end
                        if (msg_end)
                        begin
                            if (count_reg == '0)
                            begin
                                state_reg <= ST_FETCH;
                            end
                            else
                            begin
                                rounds_reg <= rounds_for(7'(n_now));
                                p_reg      <= mode_reg ? count_reg[AW-1:0] : '0;
                                state_reg  <= ST_PRIME;
                            end
                        end
                    end
                end
                ST_PRIME:
                begin
                    state_reg <= ST_MIX;
                end
                ST_MIX:
                begin
                    p_reg <= next_p;
                    if (round_end)
                    begin
                        rounds_reg <= rounds_reg - ROUNDS_W'(1);
                        if (rounds_reg == ROUNDS_W'(1))
                        begin
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH:
                begin
                    k_reg     <= '0;
                    state_reg <= ST_SHOW;
                end
                ST_SHOW:
                begin
                    if (out_fire)
                    begin
                        if (k_reg == last_idx)
                        begin
                            count_reg <= '0;
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            k_reg <= k_reg + AW'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

### rtl/xxtea_block_cipher.sv
// xxtea block cipher: encrypts or decrypts a message of 32-bit words with a 128-bit key
// message channel: one word per request, last_in marks the final word; func on the
//   first word picks encrypt (0) or decrypt (1); words stop at MAX_WORDS, that word
//   then closes the message
// result channel: the processed words in order, last_out on the final one
// key: four 32-bit registers on the apb port at byte addresses 0, 4, 8, 12
// for an n-word message: the words load, a prime state follows, then 6 + 52/n
//   rounds of n word updates in the mix state, a fetch state, then one result
//   word per cycle while result.ready is high; the mix loop is set by the single
//   read port of the message memory, which updates one word per cycle
// a one-word message skips the mix and comes back unchanged
// only one message is in flight: message.ready is low from the last word until
//   the last result request is taken
// a stalled result request holds its word on the memory read register
// reset clears the controller and the key registers; memory contents are not cleared
module xxtea_block_cipher #(
    parameter int MAX_WORDS = xxtea_pkg::DEFAULT_MAX_WORDS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    xxtea_in_if.sink                        message,
    xxtea_out_if.source                     result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [xxtea_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [xxtea_pkg::WORD_W-1:0]     pwdata,
    output logic [xxtea_pkg::WORD_W-1:0]     prdata,
    output logic                            pready
);
    import xxtea_pkg::*;

    localparam int AW = $clog2(MAX_WORDS);
    localparam int CW = $clog2(MAX_WORDS + 1);

    key_t          key_reg;
    cmd_t          cmd;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic          key_write;
    logic [1:0]    key_sel;

    // key registers, written in the apb access phase
    assign pready    = 1'b1;
    assign key_sel   = paddr[3:2];
    assign key_write = psel && penable && pwrite && pready;
    assign prdata    = key_reg[key_sel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (key_write)
        begin
            key_reg[key_sel] <= pwdata;
        end
    end

    // sequencing: load, prime, mix rounds, fetch, stream out
    xxtea_ctrl #(
        .MAX_WORDS (MAX_WORDS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (message.valid),
        .in_last   (message.last_in),
        .in_func   (message.func),
        .in_ready  (message.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .out_last  (result.last_out),
        .cmd       (cmd),
        .waddr     (waddr),
        .raddr     (raddr)
    );

    // message memory, round sum and the mix unit
    xxtea_dp #(
        .MAX_WORDS (MAX_WORDS),
        .AW        (AW)
    ) u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .waddr    (waddr),
        .raddr    (raddr),
        .data_in  (message.data_in),
        .key      (key_reg),
        .data_out (result.data_out)
    );

endmodule

### tb/xxtea_block_cipher_test.sv
`timescale 1ns / 1ps

module xxtea_block_cipher_test;
    import xxtea_pkg::*;

    localparam int MSG_MAX        = DEFAULT_MAX_WORDS;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 225;
    localparam int KEY_PHASES     = 5;
    localparam int PRINT_LIMIT    = 40;

    localparam logic FUNC_ENCRYPT = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    typedef enum int { KEY_WORD0 = 0, KEY_WORD1, KEY_WORD2, KEY_WORD3 } key_reg_t;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct {
        word_t data;
        logic  last;
    } cipher_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    word_t                 pwdata;
    word_t                 prdata;
    logic                  pready;

    xxtea_in_if  message_ch ();
    xxtea_out_if result_ch ();

    // shadow of the key registers, updated when a write is taken
    word_t        key_shadow [KEY_WORDS];
    // words of the message being loaded, and the op latched from its first word
    word_t        loading_words [$];
    logic         loading_decrypt;
    // processed words still owed by the block, oldest first
    cipher_word_t pending_words [$];

    int fail_count;
    int quiet_cycles;
    bit tx_jitter;
    bit rx_jitter;
    bit hold_request;

    xxtea_block_cipher #(
        .MAX_WORDS (MSG_MAX)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .message (message_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // data words lean toward the extremes now and then
    function automatic word_t pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        if (r < 12)
            return '1;
        return word_t'($urandom);
    endfunction

    // message lengths: mostly short, a few long or past the word limit
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(1, 3);
        if (r < 85)
            return $urandom_range(4, 10);
        if (r < 96)
            return $urandom_range(11, 40);
        return $urandom_range(MSG_MAX - 4, MSG_MAX + 6);
    endfunction

    // one term of the corrected block tea mix
    function automatic word_t mix_term(word_t y, word_t z, word_t s, int p, logic [1:0] e);
        word_t a;
        word_t b;
        word_t c;
        a = (z >> 5) ^ (y << 2);
        b = (y >> 3) ^ (z << 4);
        c = (s ^ y) + (key_shadow[2'(p) ^ e] ^ z);
        return (a + b) ^ c;
    endfunction

    // full xxtea pass over a message of two or more words, in place
    function automatic void xxtea_transform(ref word_t v [$], input logic decrypt);
        int         n;
        int         rounds;
        int         p;
        word_t      s;
        word_t      y;
        word_t      z;
        logic [1:0] e;
        n      = v.size();
        rounds = 6 + 52 / n;
        if (!decrypt)
        begin
            s = '0;
            z = v[n-1];
            repeat (rounds)
            begin
                s = s + TEA_DELTA;
                e = s[3:2];
                for (p = 0; p < n - 1; p++)
                begin
                    y    = v[p+1];
                    v[p] = v[p] + mix_term(y, z, s, p, e);
                    z    = v[p];
                end
                y      = v[0];
                v[n-1] = v[n-1] + mix_term(y, z, s, n - 1, e);
                z      = v[n-1];
            end
        end
        else
        begin
            // the sum starts where encryption left it
            s = TEA_DELTA * word_t'(rounds);
            y = v[0];
            repeat (rounds)
            begin
                e = s[3:2];
                for (p = n - 1; p > 0; p--)
                begin
                    z    = v[p-1];
                    v[p] = v[p] - mix_term(y, z, s, p, e);
                    y    = v[p];
                end
                z    = v[n-1];
                v[0] = v[0] - mix_term(y, z, s, 0, e);
                y    = v[0];
                s    = s - TEA_DELTA;
            end
        end
    endfunction

    // message side: every accepted request feeds the predictor
    always @(posedge clk)
    begin
        if (rst_n && message_ch.valid && message_ch.ready)
        begin
            if (loading_words.size() == 0)
                loading_decrypt = message_ch.func;
            loading_words.push_back(message_ch.data_in);
            // a full store closes the message even without last_in
            if (message_ch.last_in || loading_words.size() == MSG_MAX)
            begin
                // a one-word message comes back unchanged
                if (loading_words.size() > 1)
                    xxtea_transform(loading_words, loading_decrypt);
                foreach (loading_words[k])
                    pending_words.push_back('{loading_words[k], k == loading_words.size() - 1});
                loading_words.delete();
            end
        end
    end

    // result side: compare each accepted request with the oldest pending word
    always @(posedge clk)
    begin : result_check
        cipher_word_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_words.size() == 0)
            begin
                fail_count++;
                if (fail_count <= PRINT_LIMIT)
                    $display("%0t: result word %h with nothing pending", $time,
                             result_ch.data_out);
            end
            else
            begin
                want = pending_words.pop_front();
                if (result_ch.data_out !== want.data)
                begin
                    fail_count++;
                    if (fail_count <= PRINT_LIMIT)
                        $display("%0t: data_out expected %h actual %h", $time, want.data,
                                 result_ch.data_out);
                end
                if (result_ch.last_out !== want.last)
                begin
                    fail_count++;
                    if (fail_count <= PRINT_LIMIT)
                        $display("%0t: last_out expected %b actual %b", $time, want.last,
                                 result_ch.last_out);
                end
            end
        end
    end

    // result ready: random stalls, or one long hold when a test asks for it
    initial
    begin : result_sink
        int stall_left;
        stall_left      = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && hold_request)
            begin
                stall_left   = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else if (stall_left == 0 && rx_jitter)
                stall_left = gap_len();
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // watchdog: too long without any accepted request on either channel
    always @(posedge clk)
    begin
        if ((message_ch.valid && message_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no request accepted for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // offer one message word and hold it until the block takes it
    task automatic send_word(input word_t w, input logic last, input logic op);
        int gap;
        gap = tx_jitter ? gap_len() : 0;
        if (gap > 0)
        begin
            message_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        message_ch.valid   <= 1'b1;
        message_ch.data_in <= w;
        message_ch.last_in <= last;
        message_ch.func    <= op;
        do
            @(posedge clk);
        while (!(message_ch.valid === 1'b1 && message_ch.ready === 1'b1));
    endtask

    // random message; func only matters on the first word, later ones toggle freely
    task automatic send_message(input int len, input logic op);
        for (int i = 0; i < len; i++)
            send_word(pick_word(), i == len - 1, (i == 0) ? op : logic'($urandom_range(0, 1)));
    endtask

    // drop valid and let every pending word come back before going on
    task automatic wait_drained();
        message_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(input key_reg_t idx, input word_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(int'(idx) * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        key_shadow[idx] = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read_check(input key_reg_t idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CFG_ADDR_W'(int'(idx) * 4);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata !== key_shadow[idx])
        begin
            fail_count++;
            if (fail_count <= PRINT_LIMIT)
                $display("%0t: key register %s expected %h actual %h", $time, idx.name(),
                         key_shadow[idx], prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // load a whole key, then read every word back
    task automatic set_key(input word_t k0, input word_t k1, input word_t k2, input word_t k3);
        apb_write(KEY_WORD0, k0);
        apb_write(KEY_WORD1, k1);
        apb_write(KEY_WORD2, k2);
        apb_write(KEY_WORD3, k3);
        for (int i = 0; i < KEY_WORDS; i++)
            apb_read_check(key_reg_t'(i));
    endtask

    // one-word messages skip the mix, both ops, with the reset key
    task automatic test_single_word();
        for (int i = 0; i < KEY_WORDS; i++)
            apb_read_check(key_reg_t'(i));
        send_word('0, 1'b1, FUNC_ENCRYPT);
        send_word('1, 1'b1, FUNC_DECRYPT);
        send_word(word_t'($urandom), 1'b1, FUNC_ENCRYPT);
        wait_drained();
    endtask

    // key registers at their extremes and a mixed key
    task automatic test_key_registers();
        set_key('1, '1, '1, '1);
        send_word('0, 1'b0, FUNC_ENCRYPT);
        send_word('0, 1'b1, FUNC_ENCRYPT);
        wait_drained();
        set_key('0, '1, 32'h0123_4567, 32'h89ab_cdef);
    endtask

    // short messages at the data extremes, then two random ones, both ops
    task automatic test_directed();
        send_word('0, 1'b0, FUNC_ENCRYPT);
        send_word('0, 1'b1, FUNC_DECRYPT);
        send_word('1, 1'b0, FUNC_DECRYPT);
        send_word('1, 1'b1, FUNC_ENCRYPT);
        send_word(32'h8000_0001, 1'b0, FUNC_ENCRYPT);
        send_word(32'h7fff_fffe, 1'b0, FUNC_DECRYPT);
        send_word(32'h5555_aaaa, 1'b1, FUNC_DECRYPT);
        send_word('1, 1'b0, FUNC_DECRYPT);
        send_word('0, 1'b0, FUNC_ENCRYPT);
        send_word('1, 1'b0, FUNC_ENCRYPT);
        send_word('0, 1'b1, FUNC_ENCRYPT);
        send_message(5, FUNC_ENCRYPT);
        send_message(6, FUNC_DECRYPT);
        wait_drained();
    endtask

    // a full store closes the message; the next word starts a new one
    task automatic test_overlong();
        for (int i = 0; i < MSG_MAX; i++)
            send_word(pick_word(), 1'b0, (i == 0) ? FUNC_DECRYPT : logic'($urandom_range(0, 1)));
        // lone word after the full store comes back unchanged
        send_word(word_t'($urandom), 1'b1, FUNC_ENCRYPT);
        send_message(MSG_MAX, FUNC_ENCRYPT);
        wait_drained();
    endtask

    // result side held off long enough that the message side backs up
    task automatic test_backpressure();
        tx_jitter    = 1'b0;
        rx_jitter    = 1'b0;
        hold_request = 1'b1;
        repeat (4) send_message(3, logic'($urandom_range(0, 1)));
        wait_drained();
    endtask

    // random traffic under several keys, extremes first
    task automatic test_random_messages();
        int sent;
        for (int phase_idx = 0; phase_idx < KEY_PHASES; phase_idx++)
        begin
            case (phase_idx)
                0:       set_key('0, '0, '0, '0);
                1:       set_key('1, '1, '1, '1);
                default: set_key(word_t'($urandom), word_t'($urandom), word_t'($urandom),
                                 word_t'($urandom));
            endcase
            // one phase without any idling, the rest with gaps on both sides
            tx_jitter = (phase_idx != 2);
            rx_jitter = (phase_idx != 2);
            sent      = 0;
            while (sent < RANDOM_ITEMS / KEY_PHASES)
            begin
                int len;
                len = pick_length();
                send_message(len, logic'($urandom_range(0, 1)));
                sent += len;
                // now and then the sender waits for the block to empty
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
            end
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        message_ch.valid   <= 1'b0;
        message_ch.data_in <= '0;
        message_ch.last_in <= 1'b0;
        message_ch.func    <= FUNC_ENCRYPT;
        quiet_cycles       <= 0;
        fail_count   = 0;
        tx_jitter    = 1'b0;
        rx_jitter    = 1'b0;
        hold_request = 1'b0;
        foreach (key_shadow[i])
            key_shadow[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_word();
        test_key_registers();
        test_directed();
        test_overlong();
        test_backpressure();
        test_random_messages();

        // tail: anything arriving now is flagged by the result check
        wait_drained();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### xxtea_block_cipher.f
rtl/xxtea_pkg.sv
rtl/xxtea_if.sv
rtl/xxtea_dp.sv
rtl/xxtea_ctrl.sv
rtl/xxtea_block_cipher.sv
tb/xxtea_block_cipher_test.sv
